// ===== rtl/core/csb_pkg.sv =====
package csb_pkg;

  localparam int NUM_SLOTS  = 16;
  localparam int COUNT_BITS = 16;
  localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // operation codes
  localparam logic [2:0] OP_OPEN       = 3'd0;
  localparam logic [2:0] OP_CLOSE      = 3'd1;
  localparam logic [2:0] OP_UP         = 3'd2;
  localparam logic [2:0] OP_DOWN       = 3'd3;
  localparam logic [2:0] OP_OPEN_FIRST = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_BLOCK    = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  slot;
    logic [15:0] init_count;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  slot_used;
    logic [15:0] count_after;
    logic        wake;
  } rsp_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
  } free_t;

endpackage

// ===== rtl/core/csb_ram.sv =====
module csb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/csb_free_search.sv =====
module csb_free_search
  import csb_pkg::*;
(
  input  logic                 clk,
  input  logic [NUM_SLOTS-1:0] slot_open,
  output free_t                free
);

  free_t free_r;
  free_t free_nxt;

  // lowest closed slot wins
  always_comb begin
    free_nxt = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!slot_open[i]) begin
        free_nxt.found = 1'b1;
        free_nxt.idx   = SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    free_r <= free_nxt;
  end

  assign free = free_r;

endmodule

// ===== rtl/core/counting_semaphore_bank.sv =====
// channel   ports                         direction  item
// request   in_valid  in_ready  in_data   input      op, slot, init_count
// response  out_valid out_ready out_data  output     status, slot_used, count_after, wake
//
// per item, the accept edge issues the count memory read and
// the first-free search registers, the finishing edge writes back and loads the result
// the count memory read-modify-write sets the rate, one item in flight at a time
// rst_n (synchronous) closes every slot; count memory contents need no clearing
// a new item is taken while a finished result waits; execution holds only
// when the result register is still full
module counting_semaphore_bank
  import csb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // request held for the execute cycle
  req_t  req_r;
  logic  slot_ok_r;

  // open flags, one per slot
  logic [NUM_SLOTS-1:0] slot_open_r, slot_open_nxt;

  // result register
  logic out_valid_r, out_valid_nxt;
  rsp_t out_data_r, out_data_nxt;

  // count memory
  logic                  mem_we;
  logic [SLOT_W-1:0]     mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [COUNT_BITS-1:0] mem_rdata;

  free_t free;

  logic              accept;
  logic              exec_done;
  logic [SLOT_W-1:0] req_idx;
  logic [SLOT_W-1:0] in_idx;
  logic              cur_open;
  logic              init_big;
  logic [31:0]       init_ext;
  logic [COUNT_BITS-1:0] init_cnt;
  logic [COUNT_BITS-1:0] cnt_new;
  logic [31:0]       cnt_ext;
  rsp_t              rsp;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_idx   = in_data.slot[SLOT_W-1:0];
  assign req_idx  = req_r.slot[SLOT_W-1:0];

  // result register must be free (or draining) to finish an item
  assign exec_done = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  csb_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_SLOTS)
  ) u_count_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (in_idx),
    .rdata (mem_rdata)
  );

  // registered every cycle; open flags only move on exec_done
  csb_free_search u_free_search (
    .clk       (clk),
    .slot_open (slot_open_r),
    .free      (free)
  );

  // capture request
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r     <= in_data;
      slot_ok_r <= ({1'b0, in_data.slot} < 9'(NUM_SLOTS));
    end
  end

  // init count range and width adjust
  assign init_ext = 32'(req_r.init_count);
  assign init_big = init_ext > 32'(COUNT_MAX);
  assign init_cnt = init_ext[COUNT_BITS-1:0];
  assign cur_open = slot_open_r[req_idx];

  // operation decode and count update
  always_comb begin
    rsp           = '0;
    rsp.status    = ST_INVALID;
    rsp.slot_used = req_r.slot;
    slot_open_nxt = slot_open_r;
    mem_we        = 1'b0;
    mem_waddr     = req_idx;
    cnt_new       = init_cnt;

    unique case (req_r.op)
      OP_OPEN: begin
        if (slot_ok_r && !cur_open && !init_big) begin
          slot_open_nxt[req_idx] = 1'b1;
          mem_we                 = 1'b1;
          rsp.status             = ST_OK;
          rsp.count_after        = req_r.init_count;
        end
      end
      OP_CLOSE: begin
        if (slot_ok_r) begin
          slot_open_nxt[req_idx] = 1'b0;
          rsp.status             = ST_OK;
        end
      end
      OP_UP: begin
        if (slot_ok_r && cur_open) begin
          if (mem_rdata == COUNT_MAX) begin
            // already saturated, nothing to write
            rsp.status = ST_OVERFLOW;
          end else begin
            cnt_new         = mem_rdata + COUNT_BITS'(1);
            mem_we          = 1'b1;
            rsp.status      = ST_OK;
            rsp.count_after = cnt_ext[15:0];
            rsp.wake        = (mem_rdata == '0);
          end
        end
      end
      OP_DOWN: begin
        if (slot_ok_r && cur_open) begin
          if (mem_rdata == '0) begin
            rsp.status = ST_BLOCK;
          end else begin
            cnt_new         = mem_rdata - COUNT_BITS'(1);
            mem_we          = 1'b1;
            rsp.status      = ST_OK;
            rsp.count_after = cnt_ext[15:0];
          end
        end
      end
      OP_OPEN_FIRST: begin
        rsp.slot_used = 8'd0;
        mem_waddr     = free.idx;
        if (!init_big && free.found) begin
          slot_open_nxt[free.idx] = 1'b1;
          mem_we                  = 1'b1;
          rsp.status              = ST_OK;
          rsp.slot_used           = 8'(free.idx);
          rsp.count_after         = req_r.init_count;
        end
      end
      default: begin
        rsp.status = ST_INVALID;
      end
    endcase

    // only commit on the finishing cycle
    if (!exec_done) begin
      mem_we        = 1'b0;
      slot_open_nxt = slot_open_r;
    end
  end

  assign cnt_ext   = 32'(cnt_new);
  assign mem_wdata = cnt_new;

  // sequencing and result register
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_done) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = rsp;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      slot_open_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      slot_open_r <= slot_open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
